FILE: hw/rtl/cmst_pkg.sv
`default_nettype none

package cmst_pkg;

    localparam int KIND_W  = 3;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = 16;
    localparam int POS_W   = 4;
    localparam int DIST_W  = 5;
    localparam int TOTAL_W = 40;
    localparam int PROD_W  = VAL_W + CNT_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SET    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } t_entry;

endpackage

`default_nettype wire

FILE: hw/rtl/counted_multiset_table_unit.sv
// Counted multiset table: an ordered table of up to DEPTH distinct 16-bit
// values, each with a 16-bit occurrence count.
// Input channel (i_in_valid / o_in_ready) carries one operation per
// transaction: add, remove, set count, lookup or read at position.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// operation, with the distinct count and the saturated weighted total.
// One operation is in flight at a time; o_in_ready is high only when idle.
// Steps per operation, with N the number of entries in use:
//   add, lookup, set miss, remove miss: a linear scan of the N entries;
//   set hit: the scan, then two passes of the multiplier;
//   remove hit: scan to the match, one multiply, shift the rest;
//   read: one memory read at the position; unused kinds go straight to the result.
// The table sits in one memory with a single read and a single write port;
// the scan reads one entry per cycle, and the shift reads one and writes one.
// The weighted total is kept exactly; add adds the value, remove and set go
// through one shared 16 x 16 multiplier; it is saturated to 40 bits at output.
// Reset empties the table and clears the total; the memory is not cleared.
// A stalled receiver holds the result in the output register; the next
// operation is accepted while it waits, and finishes once it is taken.
`default_nettype none

module counted_multiset_table_unit
    import cmst_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [KIND_W-1:0]   i_kind,
    input  wire  [VAL_W-1:0]    i_value,
    input  wire  [CNT_W-1:0]    i_new_count,
    input  wire  [POS_W-1:0]    i_position,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_found,
    output logic [CNT_W-1:0]    o_occurrences,
    output logic [VAL_W-1:0]    o_entry_value,
    output logic [DIST_W-1:0]   o_distinct_count,
    output logic [TOTAL_W-1:0]  o_weighted_total,
    output logic                o_refused
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int UW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH + 2);
    localparam int PW = (IW > POS_W) ? IW : POS_W;
    localparam int SW = PROD_W + $clog2(DEPTH);
    localparam int XW = (SW > TOTAL_W) ? SW : TOTAL_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MUL_OLD,
        S_SUB_OLD,
        S_MUL_NEW,
        S_ADD_NEW,
        S_SHIFT,
        S_RDOUT,
        S_DONE
    } t_state;

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    t_state              r_state, n_state;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic [VAL_W-1:0]    r_value, n_value;
    logic [CNT_W-1:0]    r_new_count, n_new_count;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_rd_idx, n_rd_idx;
    logic                r_rd_vld, n_rd_vld;
    logic [IW-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]    r_cur_cnt, n_cur_cnt;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [SW-1:0]       r_sum, n_sum;
    logic [UW-1:0]       r_used, n_used;
    logic                r_res_found, n_res_found;
    logic [CNT_W-1:0]    r_res_occ, n_res_occ;
    logic [VAL_W-1:0]    r_res_ev, n_res_ev;
    logic                r_res_refused, n_res_refused;
    logic                r_out_valid, n_out_valid;
    logic                r_o_found, n_o_found;
    logic [CNT_W-1:0]    r_o_occ, n_o_occ;
    logic [VAL_W-1:0]    r_o_ev, n_o_ev;
    logic [DIST_W-1:0]   r_o_dist, n_o_dist;
    logic [TOTAL_W-1:0]  r_o_total, n_o_total;
    logic                r_o_refused, n_o_refused;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;

    logic [CNT_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [CNT_W-1:0]    cnt_inc;
    logic [IW-1:0]       slot_next;
    logic [IW-1:0]       shift_dst;
    logic [XW-1:0]       sum_x;
    logic [TOTAL_W-1:0]  total_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    assign mul_b     = (r_state == S_MUL_NEW) ? r_new_count : r_cur_cnt;
    assign mul_p     = PROD_W'(r_value) * PROD_W'(mul_b);
    assign cnt_inc   = (r_rd_data.count == CNT_MAX) ? CNT_MAX : r_rd_data.count + 1'b1;
    assign slot_next = r_slot + 1'b1;
    assign shift_dst = r_rd_idx - 1'b1;
    assign sum_x     = XW'(r_sum);
    assign total_sat = (sum_x > XW'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(sum_x);

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_value       = r_value;
        n_new_count   = r_new_count;
        n_idx         = r_idx;
        n_rd_idx      = r_rd_idx;
        n_rd_vld      = r_rd_vld;
        n_slot        = r_slot;
        n_cur_cnt     = r_cur_cnt;
        n_prod        = r_prod;
        n_sum         = r_sum;
        n_used        = r_used;
        n_res_found   = r_res_found;
        n_res_occ     = r_res_occ;
        n_res_ev      = r_res_ev;
        n_res_refused = r_res_refused;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_o_found     = r_o_found;
        n_o_occ       = r_o_occ;
        n_o_ev        = r_o_ev;
        n_o_dist      = r_o_dist;
        n_o_total     = r_o_total;
        n_o_refused   = r_o_refused;
        mem_we        = 1'b0;
        mem_waddr     = r_rd_idx[AW-1:0];
        mem_wdata     = r_rd_data;
        mem_re        = 1'b0;
        mem_raddr     = r_idx[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind        = i_kind;
                    n_value       = i_value;
                    n_new_count   = i_new_count;
                    n_res_found   = 1'b0;
                    n_res_occ     = '0;
                    n_res_ev      = '0;
                    n_res_refused = 1'b0;
                    case (i_kind)
                        KIND_ADD, KIND_REMOVE, KIND_SET, KIND_LOOKUP: begin
                            mem_re    = 1'b1;
                            mem_raddr = '0;
                            n_rd_vld  = (r_used != '0);
                            n_rd_idx  = '0;
                            n_idx     = IW'(1);
                            n_state   = S_SCAN;
                        end
                        KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = AW'(i_position);
                            n_rd_vld  = (PW'(i_position) < PW'(r_used));
                            n_state   = S_RDOUT;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_rd_vld && (r_rd_data.value == r_value)) begin
                    n_slot    = r_rd_idx;
                    n_cur_cnt = r_rd_data.count;
                    case (r_kind)
                        KIND_ADD: begin
                            mem_we          = 1'b1;
                            mem_waddr       = r_rd_idx[AW-1:0];
                            mem_wdata.value = r_value;
                            mem_wdata.count = cnt_inc;
                            if (r_rd_data.count != CNT_MAX) begin
                                n_sum = r_sum + SW'(r_value);
                            end
                            n_res_found = 1'b1;
                            n_res_occ   = cnt_inc;
                            n_state     = S_DONE;
                        end
                        KIND_REMOVE: begin
                            n_res_found = 1'b1;
                            n_res_occ   = r_rd_data.count;
                            n_state     = S_MUL_OLD;
                        end
                        KIND_SET: begin
                            n_res_found = 1'b1;
                            n_res_occ   = r_new_count;
                            n_state     = S_MUL_OLD;
                        end
                        default: begin
                            n_res_found = 1'b1;
                            n_res_occ   = r_rd_data.count;
                            n_state     = S_DONE;
                        end
                    endcase
                end else if (!r_rd_vld) begin
                    if (r_kind == KIND_ADD) begin
                        if (r_used < UW'(DEPTH)) begin
                            mem_we          = 1'b1;
                            mem_waddr       = r_used[AW-1:0];
                            mem_wdata.value = r_value;
                            mem_wdata.count = CNT_W'(1);
                            n_used          = r_used + 1'b1;
                            n_sum           = r_sum + SW'(r_value);
                            n_res_found     = 1'b1;
                            n_res_occ       = CNT_W'(1);
                        end else begin
                            n_res_refused = 1'b1;
                        end
                    end
                    n_state = S_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_rd_vld  = (r_idx < IW'(r_used));
                    n_rd_idx  = r_idx;
                    n_idx     = r_idx + 1'b1;
                end
            end
            S_MUL_OLD: begin
                n_prod  = mul_p;
                n_state = S_SUB_OLD;
            end
            S_SUB_OLD: begin
                n_sum = r_sum - SW'(r_prod);
                if (r_kind == KIND_REMOVE) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot_next[AW-1:0];
                    n_rd_vld  = (slot_next < IW'(r_used));
                    n_rd_idx  = slot_next;
                    n_idx     = slot_next + 1'b1;
                    n_state   = S_SHIFT;
                end else begin
                    n_state = S_MUL_NEW;
                end
            end
            S_MUL_NEW: begin
                n_prod          = mul_p;
                mem_we          = 1'b1;
                mem_waddr       = r_slot[AW-1:0];
                mem_wdata.value = r_value;
                mem_wdata.count = r_new_count;
                n_state         = S_ADD_NEW;
            end
            S_ADD_NEW: begin
                n_sum   = r_sum + SW'(r_prod);
                n_state = S_DONE;
            end
            S_SHIFT: begin
                if (r_rd_vld) begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_dst[AW-1:0];
                    mem_wdata = r_rd_data;
                    mem_re    = 1'b1;
                    mem_raddr = r_idx[AW-1:0];
                    n_rd_vld  = (r_idx < IW'(r_used));
                    n_rd_idx  = r_idx;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_used  = r_used - 1'b1;
                    n_state = S_DONE;
                end
            end
            S_RDOUT: begin
                if (r_rd_vld) begin
                    n_res_found = 1'b1;
                    n_res_occ   = r_rd_data.count;
                    n_res_ev    = r_rd_data.value;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_found   = r_res_found;
                    n_o_occ     = r_res_occ;
                    n_o_ev      = r_res_ev;
                    n_o_dist    = DIST_W'(r_used);
                    n_o_total   = total_sat;
                    n_o_refused = r_res_refused;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_value       <= n_value;
        r_new_count   <= n_new_count;
        r_idx         <= n_idx;
        r_rd_idx      <= n_rd_idx;
        r_slot        <= n_slot;
        r_cur_cnt     <= n_cur_cnt;
        r_prod        <= n_prod;
        r_res_found   <= n_res_found;
        r_res_occ     <= n_res_occ;
        r_res_ev      <= n_res_ev;
        r_res_refused <= n_res_refused;
        r_o_found     <= n_o_found;
        r_o_occ       <= n_o_occ;
        r_o_ev        <= n_o_ev;
        r_o_dist      <= n_o_dist;
        r_o_total     <= n_o_total;
        r_o_refused   <= n_o_refused;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_sum       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_sum       <= n_sum;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_found          = r_o_found;
    assign o_occurrences    = r_o_occ;
    assign o_entry_value    = r_o_ev;
    assign o_distinct_count = r_o_dist;
    assign o_weighted_total = r_o_total;
    assign o_refused        = r_o_refused;

endmodule

`default_nettype wire

FILE: hw/rtl/cmst_chk.sv
`default_nettype none

module cmst_chk
    import cmst_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 o_in_ready,
    input  wire                 o_out_valid,
    input  wire                 i_out_ready,
    input  wire                 o_found,
    input  wire  [CNT_W-1:0]    o_occurrences,
    input  wire  [VAL_W-1:0]    o_entry_value,
    input  wire  [DIST_W-1:0]   o_distinct_count,
    input  wire  [TOTAL_W-1:0]  o_weighted_total,
    input  wire                 o_refused
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_occurrences) && $stable(o_entry_value)
            && $stable(o_distinct_count) && $stable(o_weighted_total)
            && $stable(o_refused))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted transaction");

    a_refused_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_refused |-> !o_found && (o_occurrences == '0))
        else $error("refused add reports a match");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_occurrences == '0) && (o_entry_value == '0))
        else $error("miss carries nonzero payload");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (DEPTH > 31) || (o_distinct_count <= DIST_W'(DEPTH)))
        else $error("distinct count above table depth");

endmodule

bind counted_multiset_table_unit cmst_chk #(.DEPTH(DEPTH)) u_cmst_chk (.*);

`default_nettype wire

FILE: sim/counted_multiset_table_unit_tb.sv
`timescale 1ns / 1ps

module counted_multiset_table_unit_tb
    import cmst_pkg::*;
();

    localparam int DEPTH    = 16;
    localparam int RAND_OPS = 410;
    localparam int HOLD_OFF = 300;
    localparam int POOL_N   = 24;

    typedef struct {
        logic               found;
        logic [CNT_W-1:0]   occ;
        logic [VAL_W-1:0]   ev;
        logic [DIST_W-1:0]  dcount;
        logic [TOTAL_W-1:0] total;
        logic               refused;
    } t_reply;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    class table_checker #(int SLOTS = 16);
        logic [VAL_W-1:0]   vals[SLOTS];
        logic [CNT_W-1:0]   cnts[SLOTS];
        int unsigned        used;
        logic [TOTAL_W-1:0] total;
        t_reply             replies_due[$];
        int                 errors;

        function new();
            used   = 0;
            total  = '0;
            errors = 0;
        endfunction

        function int slot_of(logic [VAL_W-1:0] v);
            for (int i = 0; i < used; i++) begin
                if (vals[i] == v) return i;
            end
            return -1;
        endfunction

        function t_reply apply_op(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] v,
                                  logic [CNT_W-1:0] nc, logic [POS_W-1:0] pos);
            t_reply      r;
            int          s;
            logic [47:0] sum;
            r = '{default: '0};
            case (kind)
                KIND_ADD: begin
                    s = slot_of(v);
                    if (s >= 0) begin
                        if (cnts[s] != CNT_MAX) cnts[s] = cnts[s] + 1'b1;
                        r.found = 1'b1;
                        r.occ   = cnts[s];
                    end else if (used < SLOTS) begin
                        vals[used] = v;
                        cnts[used] = 1;
                        used++;
                        r.found = 1'b1;
                        r.occ   = 1;
                    end else begin
                        r.refused = 1'b1;
                    end
                end
                KIND_REMOVE: begin
                    s = slot_of(v);
                    if (s >= 0) begin
                        r.found = 1'b1;
                        r.occ   = cnts[s];
                        for (int j = s; j + 1 < used; j++) begin
                            vals[j] = vals[j+1];
                            cnts[j] = cnts[j+1];
                        end
                        used--;
                    end
                end
                KIND_SET: begin
                    s = slot_of(v);
                    if (s >= 0) begin
                        cnts[s] = nc;
                        r.found = 1'b1;
                        r.occ   = nc;
                    end
                end
                KIND_LOOKUP: begin
                    s = slot_of(v);
                    if (s >= 0) begin
                        r.found = 1'b1;
                        r.occ   = cnts[s];
                    end
                end
                KIND_READ: begin
                    if (pos < used) begin
                        r.found = 1'b1;
                        r.occ   = cnts[pos];
                        r.ev    = vals[pos];
                    end
                end
                default: ;
            endcase
            sum = '0;
            for (int i = 0; i < used; i++) begin
                sum = sum + 48'(vals[i]) * 48'(cnts[i]);
            end
            total    = (sum > 48'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            r.total  = total;
            r.dcount = used[DIST_W-1:0];
            return r;
        endfunction

        function void note_op(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] v,
                              logic [CNT_W-1:0] nc, logic [POS_W-1:0] pos);
            replies_due.insert(replies_due.size(), apply_op(kind, v, nc, pos));
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        endtask

        task check_result(t_reply got);
            t_reply want;
            if (replies_due.size() == 0) begin
                report("unexpected transaction", 0, 0);
                return;
            end
            want = replies_due.pop_front();
            if (got.found !== want.found) report("found", got.found, want.found);
            if (got.occ !== want.occ) report("occurrences", got.occ, want.occ);
            if (got.ev !== want.ev) report("entry_value", got.ev, want.ev);
            if (got.dcount !== want.dcount) report("distinct_count", got.dcount, want.dcount);
            if (got.total !== want.total) report("weighted_total", got.total, want.total);
            if (got.refused !== want.refused) report("refused", got.refused, want.refused);
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [KIND_W-1:0]  i_kind;
    logic [VAL_W-1:0]   i_value;
    logic [CNT_W-1:0]   i_new_count;
    logic [POS_W-1:0]   i_position;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_found;
    logic [CNT_W-1:0]   o_occurrences;
    logic [VAL_W-1:0]   o_entry_value;
    logic [DIST_W-1:0]  o_distinct_count;
    logic [TOTAL_W-1:0] o_weighted_total;
    logic               o_refused;

    table_checker #(DEPTH) sb;
    logic [VAL_W-1:0]      pool[POOL_N];
    int                    n_sent;

    counted_multiset_table_unit #(.DEPTH(DEPTH)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (i_kind),
        .i_value          (i_value),
        .i_new_count      (i_new_count),
        .i_position       (i_position),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_found          (o_found),
        .o_occurrences    (o_occurrences),
        .o_entry_value    (o_entry_value),
        .o_distinct_count (o_distinct_count),
        .o_weighted_total (o_weighted_total),
        .o_refused        (o_refused)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        t_reply seen;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.found   = o_found;
                seen.occ     = o_occurrences;
                seen.ev      = o_entry_value;
                seen.dcount  = o_distinct_count;
                seen.total   = o_weighted_total;
                seen.refused = o_refused;
                sb.check_result(seen);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_op(i_kind, i_value, i_new_count, i_position);
            end
        end
    end

    // Receiver: random stall per transaction, one long hold-off to back up the input.
    initial begin
        int stall;
        int taken;
        i_out_ready = 1'b0;
        taken = 0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (taken == 120) stall = HOLD_OFF;
            else if ((taken / 40) % 3 == 2) stall = 0;
            else stall = $urandom_range(0, 11);
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            @(negedge i_clk);
            taken++;
        end
    end

    task automatic send_op(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] v,
                           logic [CNT_W-1:0] nc, logic [POS_W-1:0] pos);
        int gap;
        gap = ((n_sent / 30) % 4 == 3) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_kind      = kind;
        i_value     = v;
        i_new_count = nc;
        i_position  = pos;
        i_in_valid  = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (sb.used > 0 && r < 55) return sb.vals[$urandom_range(0, sb.used - 1)];
        if (r < 90) return pool[$urandom_range(0, POOL_N - 1)];
        return VAL_W'($urandom);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return CNT_MAX;
        if (r < 20) return CNT_MAX - 1'b1;
        if (r < 30) return '0;
        if (r < 45) return CNT_W'($urandom_range(1, 20));
        return CNT_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (sb.used > 0 && $urandom_range(0, 99) < 60)
            return POS_W'($urandom_range(0, sb.used - 1));
        return POS_W'($urandom_range(0, 15));
    endfunction

    initial begin
        int                done_ops;
        int                r;
        int                add_lim, rem_lim, set_lim, look_lim;
        t_mix              mix;
        logic [KIND_W-1:0] k;

        sb          = new();
        n_sent      = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = '0;
        i_value     = '0;
        i_new_count = '0;
        i_position  = '0;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) pool[i] = VAL_W'($urandom);
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_op(KIND_LOOKUP, '0, '0, '0);
        send_op(KIND_READ, '0, '0, '0);
        send_op(KIND_REMOVE, 16'h1234, '0, '0);
        send_op(KIND_SET, 16'h1234, 16'd5, '0);
        send_op(KIND_ADD, '0, '0, '0);
        send_op(KIND_ADD, '1, '0, '0);
        send_op(KIND_ADD, '1, '0, '0);
        send_op(KIND_ADD, 16'h1234, '0, '0);
        send_op(KIND_SET, '1, CNT_MAX - 1'b1, '0);
        send_op(KIND_ADD, '1, '0, '0);
        send_op(KIND_ADD, '1, '0, '0);
        send_op(KIND_SET, 16'h1234, CNT_MAX, '0);
        send_op(KIND_LOOKUP, '1, '0, '0);
        send_op(KIND_SET, '0, '0, '0);
        send_op(KIND_READ, '0, '0, 4'd0);
        send_op(KIND_READ, '0, '0, 4'd2);
        send_op(KIND_READ, '0, '0, 4'd3);
        send_op(KIND_READ, '1, '1, 4'd15);
        send_op(KIND_REMOVE, '1, '0, '0);
        send_op(KIND_READ, '0, '0, 4'd1);
        send_op(KIND_REMOVE, '0, '0, '0);
        send_op(KIND_READ, '0, '0, 4'd0);
        send_op(KIND_READ + 3'd1, '1, '1, '1);
        send_op(KIND_READ + 3'd2, '1, '1, '1);
        send_op(KIND_READ + 3'd3, '1, '1, '1);

        done_ops = 0;
        mix      = MIX_FILL;
        while (done_ops < RAND_OPS) begin
            if (n_sent % 40 == 0) mix = t_mix'($urandom_range(0, 2));
            case (mix)
                MIX_FILL:  begin add_lim = 55; rem_lim = 65; set_lim = 75; look_lim = 85; end
                MIX_DRAIN: begin add_lim = 15; rem_lim = 55; set_lim = 67; look_lim = 80; end
                default:   begin add_lim = 30; rem_lim = 45; set_lim = 60; look_lim = 75; end
            endcase
            r = $urandom_range(0, 99);
            if (r < add_lim) k = KIND_ADD;
            else if (r < rem_lim) k = KIND_REMOVE;
            else if (r < set_lim) k = KIND_SET;
            else if (r < look_lim) k = KIND_LOOKUP;
            else if (r < 97) k = KIND_READ;
            else k = KIND_READ + KIND_W'($urandom_range(1, 3));
            send_op(k, pick_value(), pick_count(), pick_position());
            if (k <= KIND_READ) done_ops++;
        end
        i_in_valid = 1'b0;

        while (sb.replies_due.size() != 0) @(negedge i_clk);
        repeat (2 * DEPTH + 10) @(negedge i_clk);
        if (sb.errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cmst_pkg.sv
hw/rtl/counted_multiset_table_unit.sv
hw/rtl/cmst_chk.sv
sim/counted_multiset_table_unit_tb.sv
